// ===== hdl/ilt_pkg.sv =====
`timescale 1ns / 1ps

package ilt_pkg;

    localparam int POS_W  = 11;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PRIOR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } ilt_in_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [POS_W-1:0]         found_position;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         count;
    } ilt_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
        logic put;
        logic finish;
    } ilt_ctl_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic run_done;
        logic put_ok;
        logic out_free;
    } ilt_sts_t;

endpackage

// ===== hdl/ilt_ram.sv =====
`timescale 1ns / 1ps

module ilt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ilt_datapath.sv =====
`timescale 1ns / 1ps

module ilt_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ilt_pkg::ilt_in_t  in_data,
    input  ilt_pkg::ilt_ctl_t ctl,
    output ilt_pkg::ilt_sts_t sts,
    output logic             out_valid,
    input  logic             out_stall,
    output ilt_pkg::ilt_out_t out_data
);

    import ilt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    ilt_in_t           req_reg;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     rem_reg, rem_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [POS_W-1:0]  found_reg, found_next;
    logic [DATA_W-1:0] rdval_reg, rdval_next;
    ilt_out_t          out_reg;
    logic              out_valid_reg, out_valid_next;

    logic [XW-1:0]     pos_x, n_x, found_x;
    logic [CW-1:0]     n_m1;
    logic              pos_nz, in_list, ins_pos_ok, full;
    logic              is_search, is_insert, is_delete, hit, issue;
    logic [1:0]        adj;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    assign pos_x      = XW'(req_reg.position);
    assign n_x        = XW'(count_reg);
    assign pos_nz     = (pos_x != '0);
    assign in_list    = pos_nz && (pos_x <= n_x);
    assign ins_pos_ok = pos_nz && (pos_x <= n_x + XW'(1));
    assign full       = (n_x == XW'(DEPTH));
    assign n_m1       = (count_reg == '0) ? '0 : count_reg - CW'(1);

    assign is_search = (req_reg.command == CMD_LOCATE) || (req_reg.command == CMD_PRIOR)
                    || (req_reg.command == CMD_NEXT);
    assign is_insert = (req_reg.command == CMD_INSERT);
    assign is_delete = (req_reg.command == CMD_DELETE);

    // A match reports the index shifted by the offset that each search kind answers with.
    always_comb
    begin
        unique case (req_reg.command)
            CMD_LOCATE: adj = 2'd1;
            CMD_NEXT:   adj = 2'd2;
            default:    adj = 2'd0;
        endcase
    end

    assign hit     = pend_reg && is_search && (ram_rdata == req_reg.value);
    assign issue   = ctl.step && (rem_reg != '0) && !hit;
    assign found_x = XW'(pend_idx_reg) + XW'(adj);

    // Shifting overlaps reads and writes: the read pointer always runs two
    // entries ahead of the write address, so the two never meet.
    assign ram_we    = ctl.put || (ctl.step && pend_reg && (is_insert || is_delete));
    assign ram_waddr = ctl.put   ? AW'(pos_x - XW'(1)) :
                       is_insert ? pend_idx_reg + AW'(1) : pend_idx_reg - AW'(1);
    assign ram_wdata = ctl.put ? DATA_W'(req_reg.value) : ram_rdata;

    always_comb
    begin
        ptr_next    = ptr_reg;
        rem_next    = rem_reg;
        pend_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        rdval_next  = rdval_reg;
        count_next  = count_reg;
        if (ctl.setup)
        begin
            status_next = ST_OK;
            found_next  = '0;
            rdval_next  = '0;
            ptr_next    = '0;
            rem_next    = '0;
            unique case (req_reg.command)
                CMD_GET:
                begin
                    if (!in_list)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        ptr_next = AW'(pos_x - XW'(1));
                        rem_next = CW'(1);
                    end
                end
                CMD_LOCATE:
                begin
                    status_next = ST_NOTFOUND;
                    rem_next    = count_reg;
                end
                CMD_PRIOR:
                begin
                    status_next = ST_NOTFOUND;
                    ptr_next    = AW'(1);
                    rem_next    = n_m1;
                end
                CMD_NEXT:
                begin
                    status_next = ST_NOTFOUND;
                    rem_next    = n_m1;
                end
                CMD_INSERT:
                begin
                    if (!ins_pos_ok)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ptr_next = AW'(n_x - XW'(1));
                        rem_next = CW'(n_x + XW'(1) - pos_x);
                    end
                end
                CMD_DELETE:
                begin
                    if (!in_list)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        ptr_next = AW'(pos_x);
                        rem_next = CW'(n_x - pos_x);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (ctl.step)
        begin
            pend_next = issue;
            if (issue)
            begin
                ptr_next = is_insert ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                rem_next = rem_reg - CW'(1);
            end
            if (hit)
            begin
                rem_next    = '0;
                status_next = ST_OK;
                found_next  = POS_W'(found_x);
            end
            if (pend_reg && (req_reg.command == CMD_GET))
            begin
                rdval_next = ram_rdata;
            end
        end
        if (ctl.finish && (status_reg == ST_OK))
        begin
            if (is_insert)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (is_delete)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= in_data;
        end
        ptr_reg      <= ptr_next;
        rem_reg      <= rem_next;
        pend_idx_reg <= ptr_reg;
        status_reg   <= status_next;
        found_reg    <= found_next;
        rdval_reg    <= rdval_next;
        if (ctl.finish)
        begin
            out_reg.status         <= status_reg;
            out_reg.found_position <= found_reg;
            out_reg.read_value     <= $signed(rdval_reg);
            out_reg.count          <= POS_W'(count_next);
        end
    end

    ilt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign sts.run_done = (rem_reg == '0) && !pend_reg;
    assign sts.put_ok   = is_insert && ins_pos_ok && !full;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= XW'(DEPTH))
        else $error("entry count above depth");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> out_valid_reg)
        else $error("finished result not presented");

    a_pend_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(ctl.step))
        else $error("read in flight without a walk step");

endmodule

// ===== hdl/ilt_controller.sv =====
`timescale 1ns / 1ps

module ilt_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output ilt_pkg::ilt_ctl_t ctl,
    input  ilt_pkg::ilt_sts_t sts
);

    import ilt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_PUT    = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.setup  = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                ctl.step = 1'b1;
                if (sts.run_done)
                begin
                    state_next = sts.put_ok ? S_PUT : S_RESULT;
                end
            end
            S_PUT:
            begin
                ctl.put    = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_CHECK))
        else $error("accepted transaction not checked");

    a_put_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUT) |-> sts.put_ok)
        else $error("value written for a refused insert");

    a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && !sts.run_done) |=> (state_reg == S_RUN))
        else $error("walk left before completion");

endmodule

// ===== hdl/indexed_list_table.sv =====
// A transaction is loaded, checked, walked (get reads one entry; locate, prior and next scan
// up to the whole list; delete and insert move the entries behind the position), written
// for an insert, and then presented on out_valid.
// Throughput: one transaction at a time; the walk moves one entry per cycle through the
// single read port of the entry memory.
// Reset clears the entry count and the handshake state; the entry memory is not cleared.
`timescale 1ns / 1ps

module indexed_list_table #(
    parameter int DEPTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  ilt_pkg::ilt_in_t  in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output ilt_pkg::ilt_out_t out_data
);

    import ilt_pkg::*;

    ilt_ctl_t ctl;
    ilt_sts_t sts;

    ilt_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .ctl      (ctl),
        .sts      (sts)
    );

    ilt_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .ctl       (ctl),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
